// File: rtl/exponential_approach_growth_step_macros.svh
// ---------------------------------------------------------------------------
// exponential approach growth step - assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef EXPONENTIAL_APPROACH_GROWTH_STEP_MACROS_SVH
`define EXPONENTIAL_APPROACH_GROWTH_STEP_MACROS_SVH

`ifndef SYNTH
`define EAGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("eags check failed");
`define EAGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("eags check failed");
`else
`define EAGS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define EAGS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/eags_pkg.sv
// ---------------------------------------------------------------------------
// eags_pkg
// types, register codes and constants of the exponential approach step
// ---------------------------------------------------------------------------
package eags_pkg;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [1:0] REG_INITIAL_LEVEL = 2'd0;
    localparam logic [1:0] REG_LIMIT_LEVEL   = 2'd1;
    localparam logic [1:0] REG_BASE_RATE     = 2'd2;

    localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
    localparam logic [31:0] EXP_M1_Q32   = 32'd1580030169;
    localparam logic [3:0]  TAYLOR_TERMS = 4'd12;
    localparam logic [15:0] EXP_N_LIMIT  = 16'd12;

    typedef struct packed {
        logic [31:0] sample_time;
        logic [23:0] rate_multiplier;
        logic        series_start;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] level;
        logic               time_reversed;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] initial_level;
        logic signed [31:0] limit_level;
        logic [23:0]        base_rate;
    } cfg_t;

    // floor(2^32 / k), all ones for k of one
    function automatic logic [31:0] recip_q32(input logic [3:0] k);
        logic [31:0] m;
        case (k)
            4'd1:    m = 32'hFFFF_FFFF;
            4'd2:    m = 32'h8000_0000;
            4'd3:    m = 32'h5555_5555;
            4'd4:    m = 32'h4000_0000;
            4'd5:    m = 32'h3333_3333;
            4'd6:    m = 32'h2AAA_AAAA;
            4'd7:    m = 32'h2492_4924;
            4'd8:    m = 32'h2000_0000;
            4'd9:    m = 32'h1C71_C71C;
            4'd10:   m = 32'h1999_9999;
            4'd11:   m = 32'h1745_D174;
            4'd12:   m = 32'h1555_5555;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/eags_mul.sv
// ---------------------------------------------------------------------------
// eags_mul
// shared unsigned multiplier used by the multiply steps of the sequencer
// ---------------------------------------------------------------------------
module eags_mul #(
    parameter int A_W = 33,
    parameter int B_W = 32
) (
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);

    assign p = {{B_W{1'b0}}, a} * {{A_W{1'b0}}, b};

endmodule

// File: rtl/eags_apb.sv
// ---------------------------------------------------------------------------
// eags_apb
// configuration registers behind an apb-style slave port
// ---------------------------------------------------------------------------
module eags_apb
    import eags_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_INITIAL_LEVEL: cfg_reg.initial_level <= pwdata;
                REG_LIMIT_LEVEL:   cfg_reg.limit_level   <= pwdata;
                REG_BASE_RATE:     cfg_reg.base_rate     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_INITIAL_LEVEL: prdata = cfg_reg.initial_level;
            REG_LIMIT_LEVEL:   prdata = cfg_reg.limit_level;
            REG_BASE_RATE:     prdata = {8'd0, cfg_reg.base_rate};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/exponential_approach_growth_step.sv
// ---------------------------------------------------------------------------
// exponential_approach_growth_step
// first-order approach of a level toward a limit, one item per sample
// ---------------------------------------------------------------------------
// A series-start item loads the level from initial_level and is answered in
// the next cycle. Other items pass ST_RATE, ST_XLO, ST_XHI and ST_XSUM, the
// twelve Taylor terms of exp(-frac(x)) in three steps each (multiply,
// reciprocal divide, correction) and n multiplies by exp(-1), where n (0..11)
// is the integer part of the scaled rate x; both are skipped when that part
// is 12 or more. One 33x32 multiplier is shared by the multiply steps. s_ready
// is low while an item is in progress and while a result waits to be taken.
// ---------------------------------------------------------------------------
`include "exponential_approach_growth_step_macros.svh"

module exponential_approach_growth_step
    import eags_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE,
        ST_XLO,
        ST_XHI,
        ST_XSUM,
        ST_TAY_MUL,
        ST_TAY_DIV,
        ST_TAY_FIX,
        ST_EXP,
        ST_SCALE,
        ST_DONE
    } state_t;

    cfg_t               cfg;
    state_t             state_reg;
    logic [31:0]        prev_time_reg;
    logic signed [31:0] level_reg;
    logic [31:0]        dt_reg;
    logic               rev_reg;
    logic [23:0]        mult_reg;
    logic [47:0]        r_reg;
    logic [31:0]        acc_reg;
    logic [47:0]        prod_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         cnt_reg;
    logic [3:0]         k_reg;
    logic [32:0]        t_reg;
    logic [31:0]        v_reg;
    logic [31:0]        q_reg;
    logic               dneg_reg;
    logic [31:0]        dmag_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic               out_free;
    logic               in_acc;
    logic               res_load;
    logic signed [32:0] diff;
    logic [48:0]        xsum;
    logic [31:0]        x_sat;
    logic [35:0]        qk;
    logic [31:0]        rem;
    logic [31:0]        q_fixed;
    logic [32:0]        t_round;
    logic [16:0]        gain;
    logic [33:0]        delta;
    logic [33:0]        level_sum;
    logic [31:0]        level_sat;

    eags_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    eags_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_valid && s_ready;
    assign res_load = (in_acc && s_data.series_start) || (state_reg == ST_DONE && out_free);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RATE: begin
                mul_a = {9'd0, cfg.base_rate};
                mul_b = {8'd0, mult_reg};
            end
            ST_XLO: begin
                mul_a = {1'b0, dt_reg};
                mul_b = r_reg[31:0];
            end
            ST_XHI: begin
                mul_a = {1'b0, dt_reg};
                mul_b = {16'd0, r_reg[47:32]};
            end
            ST_TAY_MUL: begin
                mul_a = t_reg;
                mul_b = {frac_reg, 16'd0};
            end
            ST_TAY_DIV: begin
                mul_a = {1'b0, v_reg};
                mul_b = recip_q32(k_reg);
            end
            ST_EXP: begin
                mul_a = t_reg;
                mul_b = EXP_M1_Q32;
            end
            ST_SCALE: begin
                mul_a = {16'd0, gain};
                mul_b = dmag_reg;
            end
            default: ;
        endcase
    end

    assign diff    = {cfg.limit_level[31], cfg.limit_level} - {level_reg[31], level_reg};
    assign xsum    = {1'b0, prod_reg} + {17'd0, acc_reg};
    assign x_sat   = (xsum[48:32] != 17'd0) ? 32'hFFFF_FFFF : xsum[31:0];
    assign qk      = {4'd0, q_reg} * {32'd0, k_reg};
    assign rem     = v_reg - qk[31:0];
    assign q_fixed = q_reg + {31'd0, (rem >= {28'd0, k_reg})};
    assign t_round = t_reg + 33'd32768;
    assign gain    = 17'd65536 - t_round[32:16];

    // floor of the signed product: round the magnitude up when negative
    always_comb begin
        if (dneg_reg) begin
            delta = 34'd0 - ({2'd0, prod_reg[47:16]} + {33'd0, (prod_reg[15:0] != 16'd0)});
        end else begin
            delta = {2'd0, prod_reg[47:16]};
        end
        level_sum = {{2{level_reg[31]}}, level_reg} + delta;
        if (level_sum[33:31] == 3'b000 || level_sum[33:31] == 3'b111) begin
            level_sat = level_sum[31:0];
        end else if (level_sum[33]) begin
            level_sat = 32'h8000_0000;
        end else begin
            level_sat = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            prev_time_reg <= '0;
            level_reg     <= '0;
        end else begin
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        prev_time_reg <= s_data.sample_time;
                        if (s_data.series_start) begin
                            level_reg                <= cfg.initial_level;
                            m_data_reg.level         <= cfg.initial_level;
                            m_data_reg.time_reversed <= 1'b0;
                        end else begin
                            if (s_data.sample_time < prev_time_reg) begin
                                dt_reg  <= '0;
                                rev_reg <= 1'b1;
                            end else begin
                                dt_reg  <= s_data.sample_time - prev_time_reg;
                                rev_reg <= 1'b0;
                            end
                            mult_reg  <= s_data.rate_multiplier;
                            dneg_reg  <= diff[32];
                            dmag_reg  <= diff[32] ? 32'(-diff) : diff[31:0];
                            state_reg <= ST_RATE;
                        end
                    end
                end
                ST_RATE: begin
                    r_reg     <= mul_p[47:0];
                    state_reg <= ST_XLO;
                end
                ST_XLO: begin
                    acc_reg   <= mul_p[63:32];
                    state_reg <= ST_XHI;
                end
                ST_XHI: begin
                    prod_reg  <= mul_p[47:0];
                    state_reg <= ST_XSUM;
                end
                ST_XSUM: begin
                    if (x_sat[31:16] >= EXP_N_LIMIT) begin
                        t_reg     <= '0;
                        state_reg <= ST_SCALE;
                    end else begin
                        frac_reg  <= x_sat[15:0];
                        cnt_reg   <= x_sat[19:16];
                        k_reg     <= TAYLOR_TERMS;
                        t_reg     <= ONE_Q32;
                        state_reg <= ST_TAY_MUL;
                    end
                end
                ST_TAY_MUL: begin
                    v_reg     <= mul_p[63:32];
                    state_reg <= ST_TAY_DIV;
                end
                ST_TAY_DIV: begin
                    q_reg     <= mul_p[63:32];
                    state_reg <= ST_TAY_FIX;
                end
                ST_TAY_FIX: begin
                    t_reg <= ONE_Q32 - {1'b0, q_fixed};
                    if (k_reg == 4'd1) begin
                        state_reg <= (cnt_reg == 4'd0) ? ST_SCALE : ST_EXP;
                    end else begin
                        k_reg     <= k_reg - 4'd1;
                        state_reg <= ST_TAY_MUL;
                    end
                end
                ST_EXP: begin
                    t_reg   <= {1'b0, mul_p[63:32]};
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    prod_reg  <= mul_p[47:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        level_reg                <= level_sat;
                        m_data_reg.level         <= level_sat;
                        m_data_reg.time_reversed <= rev_reg;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `EAGS_ASSERT_NXT(a_start_loads, aclk, aresetn, in_acc && s_data.series_start,
        m_valid && m_data.level == $past(cfg.initial_level) && !m_data.time_reversed)
    `EAGS_ASSERT_NXT(a_busy_after_step, aclk, aresetn, in_acc && !s_data.series_start, !s_ready)
    `EAGS_ASSERT_IMP(a_t_bounded, aclk, aresetn, t_reg[32], t_reg[31:0] == 32'd0)

endmodule
